[sv/ial_pkg.sv]
// Shared types and codes for the indexed array list.
// Holds the opcode and status encodings and the sequencer state type.
// Has no dependencies.
package ial_pkg;

	typedef logic [2:0] opcode_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_REMOVE = 3'd1;
	localparam opcode_t OP_READ   = 3'd2;
	localparam opcode_t OP_UPDATE = 3'd3;
	localparam opcode_t OP_CLEAR  = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

endpackage

[sv/indexed_array_list.sv]
// Indexed array list: a fixed-capacity ordered list of signed words held in one memory.
// Depends on ial_pkg for the opcode, status and state encodings.
//
// One item is taken when start is high and busy is low; its result appears on word_out,
// status and entry_count, marked by done for one cycle, and is held there until the
// next item finishes; it cannot be held off. Busy covers the shift, put and done states
// on an insert and the fetch, shift and done states on a remove or a read, while update,
// clear, unused opcodes and any item that fails its checks go straight to the done state;
// done is raised for one cycle at the edge where busy falls. Inserts and removes move the
// later entries one word per cycle through the single read and single write port of the
// entry memory, so a remove at the head of a full list moves every later entry before
// busy falls. A new item may be started in the same cycle as done.
module indexed_array_list #(
	parameter int DEPTH     = 32,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ial_pkg::opcode_t    opcode,
	input  logic [5:0]          position,
	input  logic                from_end,
	input  logic signed [31:0]  word_in,
	output logic                done,
	output logic signed [31:0]  word_out,
	output ial_pkg::status_t    status,
	output logic [5:0]          entry_count
);
	import ial_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (CW > 6) ? CW : 6;

	logic [WORD_BITS-1:0] mem [DEPTH];

	state_t               state_q, state_d;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        c_q;
	logic [CW-1:0]        c_dec;
	logic [CW-1:0]        pos_q;
	opcode_t              op_q;
	status_t              st_q;
	logic                 ok_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 hold_q;
	logic                 wv_s1;
	logic [AW-1:0]        wa_s1;
	logic                 done_q;
	logic signed [31:0]   word_out_q;
	status_t              status_q;
	logic [5:0]           entry_count_q;

	logic [PW-1:0]        cnt_w, pos_w, pe;
	status_t              st_d;
	logic                 accept;
	logic                 rd_issue;
	logic [AW-1:0]        raddr;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [CW-1:0]        cnt_next;
	logic signed [63:0]   win_ext;
	logic signed [63:0]   res_ext;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign c_dec   = c_q - CW'(1);
	assign cnt_w   = PW'(count_q);
	assign pos_w   = PW'(position);
	assign win_ext = 64'(word_in);
	assign res_ext = 64'(signed'(res_q));

	// Effective position and the checks are settled as the item is taken.
	always_comb begin
		st_d = ST_OK;
		pe   = pos_w;
		case (opcode)
			OP_INSERT: begin
				if (from_end) begin
					pe = cnt_w;
				end
				if (pe > cnt_w) begin
					st_d = ST_RANGE;
				end else if (count_q == CW'(DEPTH)) begin
					st_d = ST_FULL;
				end
			end
			OP_REMOVE, OP_READ, OP_UPDATE: begin
				if (from_end) begin
					pe = cnt_w - PW'(1);
				end
				if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else if (pe >= cnt_w) begin
					st_d = ST_RANGE;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// Sequencer: next state, memory port control and the count after the item.
	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		raddr    = pos_q[AW-1:0];
		we       = 1'b0;
		waddr    = wa_s1;
		wdata    = rdata_q;
		cnt_next = count_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (st_d == ST_OK && opcode == OP_INSERT) begin
						state_d = S_SHIFT;
					end else if (st_d == ST_OK && (opcode == OP_REMOVE || opcode == OP_READ)) begin
						state_d = S_FETCH;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FETCH: begin
				raddr   = pos_q[AW-1:0];
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (op_q == OP_INSERT) begin
					raddr = c_dec[AW-1:0];
					if (c_q > pos_q) begin
						rd_issue = 1'b1;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					raddr = c_q[AW-1:0];
					if (op_q == OP_REMOVE && c_q < count_q) begin
						rd_issue = 1'b1;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_PUT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
				if (op_q == OP_CLEAR) begin
					cnt_next = '0;
				end else if (ok_q && op_q == OP_INSERT) begin
					cnt_next = count_q + CW'(1);
				end else if (ok_q && op_q == OP_REMOVE) begin
					cnt_next = count_q - CW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A shifted word is written in the cycle after its read; the new word goes in last.
		if (wv_s1) begin
			we = 1'b1;
		end else if (state_q == S_DONE && ok_q && (op_q == OP_INSERT || op_q == OP_UPDATE)) begin
			we    = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			wv_s1   <= 1'b0;
			hold_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			count_q <= cnt_next;
			done_q  <= (state_q == S_DONE);
			wv_s1   <= rd_issue;
			hold_q  <= (state_q == S_FETCH);
			if (accept) begin
				ok_q <= (st_d == ST_OK) && (opcode == OP_INSERT || opcode == OP_REMOVE ||
					opcode == OP_READ || opcode == OP_UPDATE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			st_q   <= st_d;
			pos_q  <= pe[CW-1:0];
			word_q <= win_ext[WORD_BITS-1:0];
			if (opcode == OP_INSERT) begin
				c_q <= count_q;
			end else begin
				c_q <= pe[CW-1:0] + CW'(1);
			end
		end else if (rd_issue) begin
			if (op_q == OP_INSERT) begin
				c_q   <= c_dec;
				wa_s1 <= c_q[AW-1:0];
			end else begin
				c_q   <= c_q + CW'(1);
				wa_s1 <= c_dec[AW-1:0];
			end
		end
		if (hold_q) begin
			res_q <= rdata_q;
		end
		if (state_q == S_DONE) begin
			if (ok_q && (op_q == OP_REMOVE || op_q == OP_READ)) begin
				word_out_q <= res_ext[31:0];
			end else begin
				word_out_q <= '0;
			end
			status_q      <= st_q;
			entry_count_q <= 6'(cnt_next);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign done        = done_q;
	assign word_out    = word_out_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds capacity");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_DONE))
		else $error("result strobe without a finishing cycle");

	a_pending_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> (state_q == S_SHIFT || state_q == S_PUT || state_q == S_DONE))
		else $error("shifted word pending outside a shift");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full status reported while the list has room");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item taken but the sequencer did not start");
`endif

endmodule
